/* src/gcdist_pkg.sv */
// ----------------------------------------------------------------------------
// gcdist_pkg
// Shared types and constants of the genome compatibility distance block.
// ----------------------------------------------------------------------------
package gcdist_pkg;

	localparam int MAX_INN     = 1024;
	localparam int WEIGHT_BITS = 16;
	localparam int IDX_W       = $clog2(MAX_INN);
	localparam int CNT_W       = 11;
	localparam int COEF_W      = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int SUM_W       = WEIGHT_BITS + IDX_W;
	localparam int DIST_W      = 32;
	localparam int DIV_NW      = 40;
	localparam int DIV_CW      = $clog2(DIV_NW + 1);
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [IDX_W:0]   NO_INN    = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_EXCESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISJOINT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WDIFF    = 2'd2;

	localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
	localparam logic [1:0] CMD_COMPUTE     = 2'd2;

	typedef struct packed {
		logic                   p1;
		logic [WEIGHT_BITS-1:0] w1;
		logic                   p2;
		logic [WEIGHT_BITS-1:0] w2;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_WALK  = 6'b000100,
		S_MUL   = 6'b001000,
		S_DIV   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

endpackage

/* src/gcdist_if.sv */
// ----------------------------------------------------------------------------
// gcdist_if
// Item channels: request (gene loads, compute) and response (distance).
// ----------------------------------------------------------------------------
interface gcdist_req_if;
	import gcdist_pkg::*;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    cmd;
	logic [IDX_W-1:0]              gene_innovation;
	logic signed [WEIGHT_BITS-1:0] gene_weight;
	modport source (output valid, cmd, gene_innovation, gene_weight, input ready);
	modport sink   (input valid, cmd, gene_innovation, gene_weight, output ready);
endinterface

interface gcdist_rsp_if;
	import gcdist_pkg::*;
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic [CNT_W-1:0]  excess_count;
	logic [CNT_W-1:0]  disjoint_count;
	logic [CNT_W-1:0]  matched_count;
	logic              no_match_flag;
	logic              empty_flag;
	modport source (output valid, distance, excess_count, disjoint_count, matched_count,
		no_match_flag, empty_flag, input ready);
	modport sink   (input valid, distance, excess_count, disjoint_count, matched_count,
		no_match_flag, empty_flag, output ready);
endinterface

/* src/genome_compatibility_distance_core.sv */
// ----------------------------------------------------------------------------
// genome_compatibility_distance_core
// NEAT compatibility distance over two genomes held in an innovation table.
// ----------------------------------------------------------------------------
// req channel: cmd 0/1 loads one connection gene of the first/second genome,
//   cmd 2 computes the distance, cmd 3 is dropped. A load item does a
//   read-modify-write of the table entry through its single read port.
// rsp channel: one item per compute item: distance (Q16.16, saturating),
//   excess/disjoint/matched counts and the no-match and empty flags.
// Compute: a walk over table entries 0 to hi, hi being the larger maximum
//   innovation, then the multiply state and up to three divisions in the
//   shared serial divider, then the output register. The walk also clears
//   each table entry it visits.
// Reset: coefficients return to 1.0, 1.0, 0.4; a clearing pass writes all
//   1024 table entries, during which req.ready stays low.
//   Configuration writes are taken at any time.
// A stalled rsp holds its item; further loads are still taken, and a new
//   compute result waits until the output register is free.
// ----------------------------------------------------------------------------
module genome_compatibility_distance_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gcdist_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gcdist_pkg::COEF_W-1:0]     cfg_wdata,
	gcdist_req_if.sink                        req,
	gcdist_rsp_if.source                      rsp
);
	import gcdist_pkg::*;

	state_t              state_q;
	logic [COEF_W-1:0]   c1_q, c2_q, c3_q;
	logic [CNT_W-1:0]    cnt1_q, cnt2_q;
	logic [IDX_W:0]      max1_q, max2_q;
	logic                ld_s1, ld_sel_s1;
	logic [IDX_W-1:0]    ld_inn_s1;
	logic [WEIGHT_BITS-1:0] ld_w_s1;
	logic [IDX_W-1:0]    clr_q;
	logic [IDX_W:0]      addr_q;
	logic                rv_s1;
	logic [IDX_W-1:0]    raddr_s1;
	logic [IDX_W-1:0]    hi_q, lo_q;
	logic                both_q, empty_q;
	logic [CNT_W-1:0]    n_q, e_q, d_q, m_q;
	logic [SUM_W-1:0]    sum_q;
	logic [COEF_W+CNT_W-1:0] prod_e_q, prod_d_q;
	logic [COEF_W+SUM_W-1:0] prod_w_q;
	logic [1:0]          phase_q;
	logic                div_busy_q;
	logic [DIV_NW+1:0]   dist_q;
	logic                out_v_q;

	logic                acc, acc_load, walk_issue;
	logic                v1, v2;
	logic [IDX_W-1:0]    m1, m2;
	logic                ram_we, ram_re;
	logic [IDX_W-1:0]    ram_waddr, ram_raddr;
	entry_t              ram_wdata, ent;
	logic [ENTRY_W-1:0]  ram_rdata;
	logic [WEIGHT_BITS:0] diff, absd;
	logic [DIV_NW-1:0]   div_num, div_quot;
	logic [CNT_W-1:0]    div_den;
	logic                div_start, div_done;

	assign req.ready  = (state_q == S_IDLE) && !ld_s1;
	assign acc        = req.valid && req.ready;
	assign acc_load   = acc && (req.cmd == CMD_LOAD_FIRST || req.cmd == CMD_LOAD_SECOND);
	assign walk_issue = (state_q == S_WALK) && (addr_q <= {1'b0, hi_q});

	assign v1 = max1_q != NO_INN;
	assign v2 = max2_q != NO_INN;
	assign m1 = max1_q[IDX_W-1:0];
	assign m2 = max2_q[IDX_W-1:0];

	assign ent       = entry_t'(ram_rdata);
	assign ram_re    = acc_load || walk_issue;
	assign ram_raddr = walk_issue ? addr_q[IDX_W-1:0] : req.gene_innovation;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = raddr_s1;
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
		end else if (ld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = ld_inn_s1;
			ram_wdata = ent;
			if (!ld_sel_s1 && !ent.p1) begin
				ram_wdata.p1 = 1'b1;
				ram_wdata.w1 = ld_w_s1;
			end
			if (ld_sel_s1 && !ent.p2) begin
				ram_wdata.p2 = 1'b1;
				ram_wdata.w2 = ld_w_s1;
			end
		end else if (rv_s1) begin
			ram_we = 1'b1;
		end
	end

	assign diff = {ent.w1[WEIGHT_BITS-1], ent.w1} - {ent.w2[WEIGHT_BITS-1], ent.w2};
	assign absd = diff[WEIGHT_BITS] ? (~diff + 1'b1) : diff;

	always_comb begin
		div_num = DIV_NW'({prod_e_q, 8'b0});
		div_den = n_q;
		case (phase_q)
			2'd0: begin
				div_num = DIV_NW'({prod_e_q, 8'b0});
				div_den = n_q;
			end
			2'd1: begin
				div_num = DIV_NW'({prod_d_q, 8'b0});
				div_den = n_q;
			end
			default: begin
				div_num = DIV_NW'(prod_w_q >> 4);
				div_den = m_q;
			end
		endcase
	end
	assign div_start = (state_q == S_DIV) && !div_busy_q && (div_den != '0);

	gcdist_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_INN)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	gcdist_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			c1_q       <= 16'd256;
			c2_q       <= 16'd256;
			c3_q       <= 16'd102;
			cnt1_q     <= '0;
			cnt2_q     <= '0;
			max1_q     <= NO_INN;
			max2_q     <= NO_INN;
			ld_s1      <= 1'b0;
			rv_s1      <= 1'b0;
			clr_q      <= '0;
			addr_q     <= '0;
			phase_q    <= '0;
			div_busy_q <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_EXCESS:   c1_q <= cfg_wdata;
					CFG_DISJOINT: c2_q <= cfg_wdata;
					CFG_WDIFF:    c3_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == S_DONE && (!out_v_q || rsp.ready)) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			ld_s1 <= acc_load;
			rv_s1 <= walk_issue;
			if (walk_issue) begin
				addr_q <= addr_q + 1'b1;
			end
			if (acc_load) begin
				if (req.cmd == CMD_LOAD_FIRST) begin
					if (cnt1_q != COUNT_MAX) cnt1_q <= cnt1_q + 1'b1;
					if (!v1 || {1'b0, req.gene_innovation} > max1_q)
						max1_q <= {1'b0, req.gene_innovation};
				end else begin
					if (cnt2_q != COUNT_MAX) cnt2_q <= cnt2_q + 1'b1;
					if (!v2 || {1'b0, req.gene_innovation} > max2_q)
						max2_q <= {1'b0, req.gene_innovation};
				end
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (acc && req.cmd == CMD_COMPUTE) begin
						cnt1_q  <= '0;
						cnt2_q  <= '0;
						max1_q  <= NO_INN;
						max2_q  <= NO_INN;
						addr_q  <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (!walk_issue && !rv_s1) state_q <= S_MUL;
				end
				S_MUL: begin
					phase_q    <= '0;
					div_busy_q <= 1'b0;
					state_q    <= S_DIV;
				end
				S_DIV: begin
					if (div_busy_q) begin
						if (div_done) begin
							div_busy_q <= 1'b0;
							if (phase_q == 2'd2) state_q <= S_DONE;
							else phase_q <= phase_q + 1'b1;
						end
					end else if (div_den == '0) begin
						if (phase_q == 2'd2) state_q <= S_DONE;
						else phase_q <= phase_q + 1'b1;
					end else begin
						div_busy_q <= 1'b1;
					end
				end
				S_DONE: begin
					if (!out_v_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_load) begin
			ld_sel_s1 <= req.cmd == CMD_LOAD_SECOND;
			ld_inn_s1 <= req.gene_innovation;
			ld_w_s1   <= req.gene_weight;
		end
		if (walk_issue) begin
			raddr_s1 <= addr_q[IDX_W-1:0];
		end
		if (state_q == S_IDLE && acc && req.cmd == CMD_COMPUTE) begin
			hi_q    <= (v2 && (!v1 || m2 > m1)) ? m2 : (v1 ? m1 : '0);
			lo_q    <= (m1 < m2) ? m1 : m2;
			both_q  <= v1 && v2;
			empty_q <= !v1 && !v2;
			n_q     <= (cnt1_q > cnt2_q) ? cnt1_q : cnt2_q;
			e_q     <= '0;
			d_q     <= '0;
			m_q     <= '0;
			sum_q   <= '0;
		end
		if (state_q == S_WALK && rv_s1) begin
			if (ent.p1 && ent.p2) begin
				sum_q <= sum_q + SUM_W'(absd);
				m_q   <= m_q + 1'b1;
			end else if (ent.p1 || ent.p2) begin
				if (both_q && raddr_s1 <= lo_q) d_q <= d_q + 1'b1;
				else e_q <= e_q + 1'b1;
			end
		end
		if (state_q == S_MUL) begin
			prod_e_q <= c1_q * e_q;
			prod_d_q <= c2_q * d_q;
			prod_w_q <= c3_q * sum_q;
			dist_q   <= '0;
		end
		if (state_q == S_DIV && div_busy_q && div_done) begin
			dist_q <= dist_q + (DIV_NW + 2)'(div_quot);
		end
		if (state_q == S_DONE && (!out_v_q || rsp.ready)) begin
			rsp.distance       <= (dist_q[DIV_NW+1:DIST_W] != '0) ? '1 : dist_q[DIST_W-1:0];
			rsp.excess_count   <= e_q;
			rsp.disjoint_count <= d_q;
			rsp.matched_count  <= m_q;
			rsp.no_match_flag  <= m_q == '0;
			rsp.empty_flag     <= empty_q;
		end
	end

	assign rsp.valid = out_v_q;
endmodule

/* src/gcdist_ram.sv */
// ----------------------------------------------------------------------------
// gcdist_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gcdist_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* src/gcdist_div.sv */
// ----------------------------------------------------------------------------
// gcdist_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gcdist_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [gcdist_pkg::DIV_NW-1:0]  num,
	input  logic [gcdist_pkg::CNT_W-1:0]   den,
	output logic                           done,
	output logic [gcdist_pkg::DIV_NW-1:0]  quot
);
	import gcdist_pkg::*;

	logic [DIV_NW-1:0] nq_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, nq_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quot  = nq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			nq_q  <= {nq_q[DIV_NW-2:0], fits};
			rem_q <= fits ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
		end
	end
endmodule

/* src/gcdist_checker.sv */
// ----------------------------------------------------------------------------
// gcdist_checker
// Port-level checks of the compatibility distance core, bound to the core.
// ----------------------------------------------------------------------------
module gcdist_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic [1:0]                      req_cmd,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [gcdist_pkg::DIST_W-1:0]   distance,
	input logic [gcdist_pkg::CNT_W-1:0]    excess_count,
	input logic [gcdist_pkg::CNT_W-1:0]    disjoint_count,
	input logic [gcdist_pkg::CNT_W-1:0]    matched_count,
	input logic                            no_match_flag,
	input logic                            empty_flag
);
	import gcdist_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(distance))
		else $error("stalled rsp item changed");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && empty_flag |-> distance == '0 && excess_count == '0
			&& disjoint_count == '0 && no_match_flag)
		else $error("empty result not zero");

	a_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> no_match_flag == (matched_count == '0))
		else $error("no-match flag disagrees with count");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_cmd != CMD_COMPUTE && !rsp_valid |=> !rsp_valid)
		else $error("result without compute item");
endmodule

bind genome_compatibility_distance_core gcdist_checker u_gcdist_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_cmd        (req.cmd),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.distance       (rsp.distance),
	.excess_count   (rsp.excess_count),
	.disjoint_count (rsp.disjoint_count),
	.matched_count  (rsp.matched_count),
	.no_match_flag  (rsp.no_match_flag),
	.empty_flag     (rsp.empty_flag)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Genome compatibility distance: gene loads into both genomes and compute
// items go in under random gaps and back-pressure; every distance item is
// checked field by field against a scoreboard predictor, across several
// coefficient settings including all-zero and all-max.
// ----------------------------------------------------------------------------
module testbench;
	import gcdist_pkg::*;

	localparam int LIMIT = 20000000;
	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef struct {
		logic [1:0]                    cmd;
		logic [IDX_W-1:0]              inn;
		logic signed [WEIGHT_BITS-1:0] wgt;
	} gene_item_t;

	typedef struct {
		logic [DIST_W-1:0] distance;
		logic [CNT_W-1:0]  excess;
		logic [CNT_W-1:0]  disjoint;
		logic [CNT_W-1:0]  matched;
		logic              no_match;
		logic              empty;
	} dist_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_wdata;

	gcdist_req_if req_if();
	gcdist_rsp_if rsp_if();

	genome_compatibility_distance_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .req(req_if.sink), .rsp(rsp_if.source)
	);

	always #5 clk = ~clk;

	gene_item_t pending_genes[$];
	dist_item_t expected_dists[$];
	int         gap_pct = 14;
	int         stall_pct = 14;
	int         mismatches = 0;
	int         cycles = 0;
	int         loaded_items = 0;

	// scoreboard copy of the block state
	logic [COEF_W-1:0]             c_excess, c_disjoint, c_wdiff;
	bit                            has1[MAX_INN], has2[MAX_INN];
	logic signed [WEIGHT_BITS-1:0] wt1[MAX_INN], wt2[MAX_INN];
	int                            cnt1, cnt2, max1, max2;

	function automatic void clear_genomes();
		for (int i = 0; i < MAX_INN; i++) begin
			has1[i] = 0; has2[i] = 0; wt1[i] = '0; wt2[i] = '0;
		end
		cnt1 = 0; cnt2 = 0; max1 = -1; max2 = -1;
	endfunction

	function automatic void load_gene(bit second, int inn, logic signed [WEIGHT_BITS-1:0] w);
		if (!second) begin
			if (!has1[inn]) begin has1[inn] = 1; wt1[inn] = w; end
			if (cnt1 < 2047) cnt1++;
			if (inn > max1) max1 = inn;
		end else begin
			if (!has2[inn]) begin has2[inn] = 1; wt2[inn] = w; end
			if (cnt2 < 2047) cnt2++;
			if (inn > max2) max2 = inn;
		end
	endfunction

	function automatic dist_item_t compute_distance();
		dist_item_t r;
		bit                both;
		int                hi, lo, e, d, m, n;
		longint            sum, df;
		longint unsigned   total;
		both = (max1 >= 0) && (max2 >= 0);
		hi = (max1 > max2) ? max1 : max2;
		lo = (max1 < max2) ? max1 : max2;
		e = 0; d = 0; m = 0; sum = 0; total = 0;
		n = (cnt1 > cnt2) ? cnt1 : cnt2;
		for (int i = 0; i <= hi; i++) begin
			if (has1[i] && has2[i]) begin
				df = longint'(wt1[i]) - longint'(wt2[i]);
				sum += (df < 0) ? -df : df;
				m++;
			end else if (has1[i] || has2[i]) begin
				if (both && i <= lo) d++;
				else e++;
			end
		end
		if (n != 0) begin
			total += (longint'(c_excess) * e * 256) / n;
			total += (longint'(c_disjoint) * d * 256) / n;
		end
		if (m != 0) total += (longint'(c_wdiff) * sum) / (longint'(m) * 16);
		if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
		r.distance = total[31:0];
		r.excess   = (e > 2047) ? 11'd2047 : e[10:0];
		r.disjoint = (d > 2047) ? 11'd2047 : d[10:0];
		r.matched  = (m > 2047) ? 11'd2047 : m[10:0];
		r.no_match = (m == 0);
		r.empty    = (max1 < 0) && (max2 < 0);
		clear_genomes();
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		gene_item_t g;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				case (req_if.cmd)
					CMD_LOAD_FIRST:  load_gene(1'b0, int'(req_if.gene_innovation),
						req_if.gene_weight);
					CMD_LOAD_SECOND: load_gene(1'b1, int'(req_if.gene_innovation),
						req_if.gene_weight);
					CMD_COMPUTE:     expected_dists.insert(expected_dists.size(),
						compute_distance());
					default: ;
				endcase
			end
			if (!req_if.valid || req_if.ready) begin
				if (pending_genes.size() > 0 && $urandom_range(99) >= gap_pct) begin
					g = pending_genes.pop_front();
					req_if.valid           <= 1'b1;
					req_if.cmd             <= g.cmd;
					req_if.gene_innovation <= g.inn;
					req_if.gene_weight     <= g.wgt;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		dist_item_t x;
		dist_item_t a;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				a.distance = rsp_if.distance;
				a.excess   = rsp_if.excess_count;
				a.disjoint = rsp_if.disjoint_count;
				a.matched  = rsp_if.matched_count;
				a.no_match = rsp_if.no_match_flag;
				a.empty    = rsp_if.empty_flag;
				if (expected_dists.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected distance item %h", a.distance);
				end else begin
					x = expected_dists.pop_front();
					if (a.distance !== x.distance || a.excess !== x.excess ||
						a.disjoint !== x.disjoint || a.matched !== x.matched ||
						a.no_match !== x.no_match || a.empty !== x.empty) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp d=%h e=%0d j=%0d m=%0d nm=%b em=%b, got d=%h e=%0d j=%0d m=%0d nm=%b em=%b",
								x.distance, x.excess, x.disjoint, x.matched, x.no_match, x.empty,
								a.distance, a.excess, a.disjoint, a.matched, a.no_match, a.empty);
					end
				end
			end
			rsp_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic push(logic [1:0] cmd, int inn, int w);
		gene_item_t g;
		g.cmd = cmd; g.inn = inn[IDX_W-1:0]; g.wgt = w[WEIGHT_BITS-1:0];
		pending_genes.insert(pending_genes.size(), g);
		if (cmd != CMD_NONE) loaded_items++;
	endtask

	task automatic settle();
		while (pending_genes.size() > 0 || req_if.valid || expected_dists.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_EXCESS:   c_excess = val;
			CFG_DISJOINT: c_disjoint = val;
			CFG_WDIFF:    c_wdiff = val;
			default: ;
		endcase
	endtask

	task automatic set_coeffs(int a, int b, int c);
		settle();
		write_reg(CFG_EXCESS, COEF_W'(a));
		write_reg(CFG_DISJOINT, COEF_W'(b));
		write_reg(CFG_WDIFF, COEF_W'(c));
	endtask

	// one genome pair with random overlap, stray compute and cmd 3 items, then a compute
	task automatic genome_pair();
		int span, n, inn;
		int pool[8];
		span = ($urandom_range(9) == 0) ? 1023 : $urandom_range(3, 63);
		n = $urandom_range(0, 40);
		foreach (pool[i]) pool[i] = $urandom_range(0, span);
		for (int i = 0; i < n; i++) begin
			inn = ($urandom_range(1) == 0) ? pool[$urandom_range(7)] : $urandom_range(0, span);
			if ($urandom_range(19) == 0)
				push(CMD_NONE, $urandom, $urandom);
			else if ($urandom_range(29) == 0)
				push(CMD_COMPUTE, $urandom, $urandom);
			else
				push(($urandom_range(1) == 0) ? CMD_LOAD_FIRST : CMD_LOAD_SECOND,
					inn, $urandom);
		end
		push(CMD_COMPUTE, $urandom, $urandom);
	endtask

	initial begin
		int a, b, c;
		cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
		req_if.valid = 1'b0; req_if.cmd = '0; req_if.gene_innovation = '0;
		req_if.gene_weight = '0; rsp_if.ready = 1'b0;
		c_excess = 16'd256; c_disjoint = 16'd256; c_wdiff = 16'd102;
		clear_genomes();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		push(CMD_COMPUTE, 0, 0);
		push(CMD_LOAD_FIRST, 0, 32767);
		push(CMD_COMPUTE, 0, 0);
		push(CMD_LOAD_SECOND, 1023, -32768);
		push(CMD_COMPUTE, 0, 0);
		push(CMD_LOAD_FIRST, 5, -32768);
		push(CMD_LOAD_SECOND, 5, 32767);
		push(CMD_LOAD_FIRST, 5, 0);
		push(CMD_LOAD_FIRST, 3, 100);
		push(CMD_LOAD_SECOND, 9, -1);
		push(CMD_NONE, 7, 55);
		push(CMD_LOAD_SECOND, 1, 4096);
		push(CMD_LOAD_FIRST, 1, -4096);
		push(CMD_COMPUTE, 0, 0);
		push(CMD_LOAD_FIRST, 2, 1);
		push(CMD_LOAD_SECOND, 4, 2);
		push(CMD_COMPUTE, 0, 0);

		// repeated innovations at maximum coefficients
		set_coeffs(65535, 65535, 65535);
		for (int i = 0; i < 40; i++) push(CMD_LOAD_FIRST, i % 37, $urandom);
		push(CMD_LOAD_SECOND, 36, -32768);
		push(CMD_LOAD_SECOND, 0, 32767);
		push(CMD_COMPUTE, 0, 0);
		set_coeffs(0, 0, 0);
		repeat (3) genome_pair();

		for (int phase = 0; loaded_items < 1250; phase++) begin
			case (phase % 4)
				0: begin a = 65535; b = 65535; c = 65535; end
				1: begin a = 0; b = 0; c = 0; end
				default: begin a = $urandom_range(65535); b = $urandom_range(65535);
					c = $urandom_range(65535); end
			endcase
			set_coeffs(a, b, c);
			gap_pct = (phase == 2) ? 0 : 14;
			stall_pct = (phase == 2) ? 0 : 14;
			for (int k = 0; k < 10; k++) genome_pair();
		end

		settle();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
src/gcdist_pkg.sv
src/gcdist_if.sv
src/gcdist_ram.sv
src/gcdist_div.sv
src/genome_compatibility_distance_core.sv
src/gcdist_checker.sv
dv/testbench.sv
